// ===== sv/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// Types, constants and codes shared by the scoped timing statistics table.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int NUM_POINTS = 16;
    localparam int TIME_BITS  = 32;

    // Min/max words hold at least the 32 bits that leave the block.
    localparam int ST_BITS  = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int IDX_BITS = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
    localparam int CNT_BITS = $clog2(NUM_POINTS + 1);

    typedef logic [TIME_BITS-1:0] tm_t;
    typedef logic [ST_BITS-1:0]   st_t;
    typedef logic [IDX_BITS-1:0]  idx_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    localparam logic [7:0] DEPTH_MAX = 8'hFF;

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_END   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_RESET = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_UNMATCHED = 2'd2,
        ST_MISSING   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_READ,
        S_MODIFY
    } state_t;

    typedef struct packed {
        tm_t         start;
        logic [7:0]  depth;
        logic [63:0] sum;
        logic [31:0] count;
        st_t         shortest;
        st_t         longest;
    } entry_t;

    localparam entry_t EMPTY_ENTRY = '{
        start:    '0,
        depth:    '0,
        sum:      '0,
        count:    '0,
        shortest: '1,
        longest:  '0
    };

    // Statistics memory control.
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr_all;
        idx_t rd_addr;
        idx_t wr_addr;
    } mem_ctl_t;

    // Key store control and lookup result.
    typedef struct packed {
        logic sample;
        logic alloc;
    } key_ctl_t;

    typedef struct packed {
        logic hit;
        logic full;
        idx_t idx;
    } key_lookup_t;

endpackage

// ===== sv/sts_if.sv =====
// ----------------------------------------------------------------------------
// sts_if
// Valid/ready channels for requests and results of the statistics table.
// ----------------------------------------------------------------------------
interface sts_req_if ();
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] point_key;
    logic [31:0] timestamp;

    modport source (output valid, output cmd, output point_key, output timestamp,
                    input ready);
    modport sink   (input valid, input cmd, input point_key, input timestamp,
                    output ready);
endinterface

interface sts_rsp_if ();
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] interval_count;
    logic [63:0] total_time;
    logic [31:0] min_time;
    logic [31:0] max_time;
    logic [7:0]  nest_depth;

    modport source (output valid, output status, output interval_count,
                    output total_time, output min_time, output max_time,
                    output nest_depth, input ready);
    modport sink   (input valid, input status, input interval_count,
                    input total_time, input min_time, input max_time,
                    input nest_depth, output ready);
endinterface

// ===== sv/scoped_timing_statistics_table_core.sv =====
// ----------------------------------------------------------------------------
// scoped_timing_statistics_table_core
// Timing point table: tag lookup, statistics read-modify-write, result out.
// ----------------------------------------------------------------------------
// Begin, end and query hits pass S_LOOKUP, S_READ and S_MODIFY and show their
// result from S_MODIFY; reset-stats, query misses and table-full requests answer
// from S_LOOKUP. A new request is taken only back in S_IDLE, after the registered
// tag match and the statistics memory read-modify-write; a waiting result stalls.
// Reset: asynchronous; clears control, fill count and entry valid bits at once,
// no clearing pass. A request is taken while a result still waits downstream.
// ----------------------------------------------------------------------------
module scoped_timing_statistics_table_core
    import sts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sts_req_if.sink   req,
    sts_rsp_if.source rsp
);

    state_t      state_reg, state_next;
    cmd_t        cmd_reg;
    logic [15:0] key_reg;
    tm_t         ts_reg;
    idx_t        idx_reg, idx_next;
    entry_t      ent_reg;
    tm_t         elapsed_reg;

    logic        out_valid_reg;
    status_t     out_status_reg;
    entry_t      out_ent_reg;

    key_ctl_t    key_ctl;
    key_lookup_t lk;
    mem_ctl_t    mem_ctl;
    entry_t      rd_entry;

    logic        out_free;
    logic        out_load;
    status_t     out_status;
    entry_t      out_ent;

    entry_t      new_ent;
    status_t     mod_status;
    st_t         el_st;
    logic [63:0] el_64;

    sts_keys u_keys (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (key_ctl),
        .sample_key (req.point_key),
        .alloc_key  (key_reg),
        .lookup     (lk)
    );

    sts_stat_mem u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mem_ctl),
        .wr_data  (new_ent),
        .rd_entry (rd_entry)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    // Entry update for begin and end.
    always_comb
    begin
        el_st      = st_t'(elapsed_reg);
        el_64      = 64'(elapsed_reg);
        new_ent    = ent_reg;
        mod_status = ST_OK;
        if (cmd_reg == CMD_BEGIN)
        begin
            if (ent_reg.depth == 8'd0)
            begin
                new_ent.start = ts_reg;
            end
            if (ent_reg.depth != DEPTH_MAX)
            begin
                new_ent.depth = ent_reg.depth + 8'd1;
            end
        end
        else if (cmd_reg == CMD_END)
        begin
            if (ent_reg.depth == 8'd0)
            begin
                mod_status = ST_UNMATCHED;
            end
            else
            begin
                new_ent.depth = ent_reg.depth - 8'd1;
                // Close the outermost interval.
                if (ent_reg.depth == 8'd1)
                begin
                    new_ent.sum   = ent_reg.sum + el_64;
                    new_ent.count = ent_reg.count + 32'd1;
                    if (el_st < ent_reg.shortest)
                    begin
                        new_ent.shortest = el_st;
                    end
                    if (el_st > ent_reg.longest)
                    begin
                        new_ent.longest = el_st;
                    end
                end
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        key_ctl         = '0;
        mem_ctl         = '0;
        mem_ctl.rd_addr = lk.idx;
        mem_ctl.wr_addr = idx_reg;
        out_load        = 1'b0;
        out_status      = ST_OK;
        out_ent         = EMPTY_ENTRY;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_ctl.sample = 1'b1;
                    state_next     = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                unique case (cmd_reg)
                    CMD_RESET:
                    begin
                        if (out_free)
                        begin
                            mem_ctl.clr_all = 1'b1;
                            out_load        = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                    CMD_QUERY:
                    begin
                        if (lk.hit)
                        begin
                            mem_ctl.rd = 1'b1;
                            idx_next   = lk.idx;
                            state_next = S_READ;
                        end
                        else if (out_free)
                        begin
                            out_load   = 1'b1;
                            out_status = ST_MISSING;
                            state_next = S_IDLE;
                        end
                    end
                    CMD_BEGIN, CMD_END:
                    begin
                        if (lk.hit || !lk.full)
                        begin
                            // Allocate the next free entry on a miss.
                            key_ctl.alloc = !lk.hit;
                            mem_ctl.rd    = 1'b1;
                            idx_next      = lk.idx;
                            state_next    = S_READ;
                        end
                        else if (out_free)
                        begin
                            out_load   = 1'b1;
                            out_status = ST_FULL;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_READ:
            begin
                state_next = S_MODIFY;
            end
            S_MODIFY:
            begin
                if (out_free)
                begin
                    mem_ctl.wr = (cmd_reg != CMD_QUERY);
                    out_load   = 1'b1;
                    out_status = mod_status;
                    out_ent    = new_ent;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (state_reg == S_IDLE && req.valid)
        begin
            cmd_reg <= cmd_t'(req.cmd);
            key_reg <= req.point_key;
            ts_reg  <= tm_t'(req.timestamp);
        end
        if (state_reg == S_READ)
        begin
            ent_reg     <= rd_entry;
            elapsed_reg <= ts_reg - rd_entry.start;
        end
        if (out_load)
        begin
            out_status_reg <= out_status;
            out_ent_reg    <= out_ent;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.interval_count = out_ent_reg.count;
    assign rsp.total_time     = out_ent_reg.sum;
    assign rsp.min_time       = out_ent_reg.shortest[31:0];
    assign rsp.max_time       = out_ent_reg.longest[31:0];
    assign rsp.nest_depth     = out_ent_reg.depth;

endmodule

// ===== sv/sts_stat_mem.sv =====
// ----------------------------------------------------------------------------
// sts_stat_mem
// Per-entry statistics memory with one read and one write port, registered
// read data and a valid bit per entry; an invalid entry reads as empty.
// ----------------------------------------------------------------------------
module sts_stat_mem
    import sts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_ctl_t ctl,
    input  entry_t   wr_data,
    output entry_t   rd_entry
);

    entry_t                 ram [NUM_POINTS];
    entry_t                 rd_data_reg;
    logic                   rd_valid_reg;
    logic [NUM_POINTS-1:0]  valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            ram[ctl.wr_addr] <= wr_data;
        end
        if (ctl.rd)
        begin
            rd_data_reg <= ram[ctl.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop every entry back to empty statistics.
            if (ctl.clr_all)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr)
            begin
                valid_reg[ctl.wr_addr] <= 1'b1;
            end
            if (ctl.rd)
            begin
                rd_valid_reg <= valid_reg[ctl.rd_addr];
            end
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : EMPTY_ENTRY;

endmodule

// ===== sv/sts_keys.sv =====
// ----------------------------------------------------------------------------
// sts_keys
// Tag store with fill count: registered match of a request tag against all
// allocated entries, first-match encode and in-order allocation.
// ----------------------------------------------------------------------------
module sts_keys
    import sts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  key_ctl_t    ctl,
    input  logic [15:0] sample_key,
    input  logic [15:0] alloc_key,
    output key_lookup_t lookup
);

    logic [15:0]           key_store [NUM_POINTS];
    logic [NUM_POINTS-1:0] match_reg;
    cnt_t                  used_reg;
    logic                  hit;
    idx_t                  hit_idx;

    always_ff @(posedge clk)
    begin
        if (ctl.alloc)
        begin
            key_store[used_reg[IDX_BITS-1:0]] <= alloc_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            match_reg <= '0;
        end
        else
        begin
            if (ctl.alloc)
            begin
                used_reg <= used_reg + cnt_t'(1);
            end
            if (ctl.sample)
            begin
                for (int i = 0; i < NUM_POINTS; i++)
                begin
                    match_reg[i] <= (cnt_t'(i) < used_reg) && (key_store[i] == sample_key);
                end
            end
        end
    end

    // Take the lowest matching entry; tags are unique anyway.
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NUM_POINTS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit     = 1'b1;
                hit_idx = idx_t'(i);
            end
        end
    end

    assign lookup.hit  = hit;
    assign lookup.full = (used_reg == cnt_t'(NUM_POINTS));
    assign lookup.idx  = hit ? hit_idx : used_reg[IDX_BITS-1:0];

endmodule
